/* src/lik_pkg.sv */
// ----------------------------------------------------------------------------
// lik_pkg
// Shared widths, constants and the arctangent table for the leg IK pipeline.
// ----------------------------------------------------------------------------
package lik_pkg;

  localparam int POS_W    = 16;
  localparam int LEN_W    = 15;
  localparam int NW       = 36;
  localparam int SQ_W     = 62;
  localparam int SQ_STAGES = SQ_W / 2;
  localparam int AT_IN_W  = 37;
  localparam int AT_W     = 44;
  localparam int ACC_W    = 36;
  localparam int NORM_EXP = 39;
  localparam int NORM_ST  = 4;
  localparam int ATAN_TAB_LEN = 24;

  localparam logic signed [ACC_W-1:0] PI_Q30 = 36'sd3373259426;

  localparam logic [31:0] ATAN_TAB [ATAN_TAB_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef enum logic [1:0] {
    CFG_SHOULDER_OFFSET = 2'd0,
    CFG_UPPER_LINK      = 2'd1,
    CFG_LOWER_LINK      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                    bad;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic signed [NW-1:0]    n;
    logic signed [NW-1:0]    n2a;
  } side_t;

endpackage

/* src/lik_sqrt.sv */
// ----------------------------------------------------------------------------
// lik_sqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module lik_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [lik_pkg::SQ_W-1:0]   rad,
  output logic [lik_pkg::SQ_W/2-1:0] root
);
  import lik_pkg::*;

  logic [SQ_W-1:0] v_r [SQ_STAGES];
  logic [SQ_W-1:0] q_r [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    localparam logic [SQ_W-1:0] Bit = {{(SQ_W-1){1'b0}}, 1'b1} << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] vi, qi, t, v_nxt, q_nxt;

    if (k == 0) begin : g_first
      assign vi = rad;
      assign qi = '0;
    end else begin : g_next
      assign vi = v_r[k-1];
      assign qi = q_r[k-1];
    end

    always_comb begin
      t = qi + Bit;
      if (vi >= t) begin
        v_nxt = vi - t;
        q_nxt = (qi >> 1) + Bit;
      end else begin
        v_nxt = vi;
        q_nxt = qi >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k] <= v_nxt;
        q_r[k] <= q_nxt;
      end
    end
  end

  assign root = q_r[SQ_STAGES-1][SQ_W/2-1:0];

endmodule

/* src/lik_atan2.sv */
// ----------------------------------------------------------------------------
// lik_atan2
// Pipelined atan2: quadrant fold, staged normalisation, vectoring CORDIC.
// ----------------------------------------------------------------------------
module lik_atan2 #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [lik_pkg::AT_IN_W-1:0]  y_in,
  input  logic signed [lik_pkg::AT_IN_W-1:0]  x_in,
  output logic signed [lik_pkg::ACC_W-1:0]    ang
);
  import lik_pkg::*;

  localparam int Lat = 1 + NORM_ST + CORDIC_STAGES;
  localparam int NormTestA  [NORM_ST] = '{32, 8, 2, 0};
  localparam int NormShiftA [NORM_ST] = '{32, 8, 2, 1};
  localparam int NormTestB  [NORM_ST] = '{16, 4, 1, 0};
  localparam int NormShiftB [NORM_ST] = '{16, 4, 1, 0};

  logic signed [AT_W-1:0]  x_r [Lat];
  logic signed [AT_W-1:0]  y_r [Lat];
  logic signed [ACC_W-1:0] a_r [Lat];
  logic                    z_r [Lat];

  function automatic logic below(input logic signed [AT_W-1:0] xv,
                                 input logic signed [AT_W-1:0] yv, input int k);
    logic signed [AT_W-1:0] lim;
    lim = $signed({{(AT_W-1){1'b0}}, 1'b1} << (NORM_EXP - k));
    return (xv < lim) && (yv < lim) && (yv > -lim);
  endfunction

  for (genvar k = 0; k < Lat; k++) begin : g_stage
    logic signed [AT_W-1:0]  xi, yi, x_nxt, y_nxt;
    logic signed [ACC_W-1:0] ai, a_nxt;
    logic                    zi;

    if (k == 0) begin : g_fold
      assign xi = {{(AT_W-AT_IN_W){x_in[AT_IN_W-1]}}, x_in};
      assign yi = {{(AT_W-AT_IN_W){y_in[AT_IN_W-1]}}, y_in};
      assign ai = '0;
      assign zi = (x_in == '0) && (y_in == '0);
      always_comb begin
        if (xi < 0) begin
          x_nxt = -xi;
          y_nxt = -yi;
          a_nxt = (yi >= 0) ? PI_Q30 : -PI_Q30;
        end else begin
          x_nxt = xi;
          y_nxt = yi;
          a_nxt = ai;
        end
      end
    end else if (k <= NORM_ST) begin : g_norm
      logic signed [AT_W-1:0] x_mid, y_mid;
      assign xi = x_r[k-1];
      assign yi = y_r[k-1];
      assign ai = a_r[k-1];
      assign zi = z_r[k-1];
      always_comb begin
        x_mid = xi;
        y_mid = yi;
        if (below(xi, yi, NormTestA[k-1])) begin
          x_mid = xi <<< NormShiftA[k-1];
          y_mid = yi <<< NormShiftA[k-1];
        end
        x_nxt = x_mid;
        y_nxt = y_mid;
        if (below(x_mid, y_mid, NormTestB[k-1])) begin
          x_nxt = x_mid <<< NormShiftB[k-1];
          y_nxt = y_mid <<< NormShiftB[k-1];
        end
        a_nxt = ai;
      end
    end else begin : g_rot
      localparam int I = k - 1 - NORM_ST;
      localparam logic signed [ACC_W-1:0] T = $signed({{(ACC_W-32){1'b0}}, ATAN_TAB[I]});
      assign xi = x_r[k-1];
      assign yi = y_r[k-1];
      assign ai = a_r[k-1];
      assign zi = z_r[k-1];
      always_comb begin
        if (yi > 0) begin
          x_nxt = xi + (yi >>> I);
          y_nxt = yi - (xi >>> I);
          a_nxt = ai + T;
        end else begin
          x_nxt = xi - (yi >>> I);
          y_nxt = yi + (xi >>> I);
          a_nxt = ai - T;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k] <= x_nxt;
        y_r[k] <= y_nxt;
        a_r[k] <= a_nxt;
        z_r[k] <= zi;
      end
    end
  end

  assign ang = z_r[Lat-1] ? '0 : a_r[Lat-1];

endmodule

/* src/leg_inverse_kinematics_unit.sv */
// ----------------------------------------------------------------------------
// leg_inverse_kinematics_unit
// Closed-form three-joint leg inverse kinematics, one foot target per item.
// ----------------------------------------------------------------------------
// Takes one foot target per cycle and returns the shoulder, arm and forearm
// angles. The pipeline is made of the squares and sums registers, the
// 31-stage root pipeline, the atan2 pipelines (fold, normalisation and
// CORDIC stages) and the final sums and rounding registers. A stalled output
// holds the whole pipeline; otherwise a new item is taken every cycle.
// Targets out of reach come back with unreachable set and all angles zero.
// Link lengths must be written through the cfg port only while no item is
// in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics_unit #(
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lik_pkg::POS_W-1:0]    in_foot_x,
  input  logic signed [lik_pkg::POS_W-1:0]    in_foot_y,
  input  logic signed [lik_pkg::POS_W-1:0]    in_foot_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [15:0]                  out_shoulder_angle,
  output logic signed [15:0]                  out_arm_angle,
  output logic [13:0]                         out_forearm_angle,
  output logic                                out_unreachable,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [lik_pkg::LEN_W-1:0]           cfg_data
);
  import lik_pkg::*;

  localparam int AtanLat = 1 + NORM_ST + CORDIC_STAGES;
  localparam int Lat     = 6 + SQ_STAGES + AtanLat + 2;
  localparam int ShOut   = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] Half =
    $signed({{(ACC_W-1){1'b0}}, 1'b1} << (ShOut - 1));

  logic [LEN_W-1:0] shoulder_offset_r, upper_link_r, lower_link_r;
  logic [Lat-1:0]   vld_r, vld_nxt;
  logic             en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shoulder_offset_r <= '0;
      upper_link_r      <= LEN_W'(1);
      lower_link_r      <= LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SHOULDER_OFFSET: shoulder_offset_r <= cfg_data;
        CFG_UPPER_LINK:      upper_link_r      <= cfg_data;
        CFG_LOWER_LINK:      lower_link_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !(vld_r[Lat-1] && out_stall);
  assign in_stall = !en;
  assign vld_nxt  = {vld_r[Lat-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // squares
  logic signed [POS_W-1:0] x1_r, y1_r, z1_r;
  logic [30:0]             xx1_r, yy1_r, zz1_r;
  logic [29:0]             ss1_r, aa1_r, ff1_r, af1_r;
  logic                    badlen1_r;
  logic signed [31:0]      xx_nxt, yy_nxt, zz_nxt;

  assign xx_nxt = in_foot_x * in_foot_x;
  assign yy_nxt = in_foot_y * in_foot_y;
  assign zz_nxt = in_foot_z * in_foot_z;

  // sums
  logic signed [POS_W-1:0] x2_r, y2_r, z2_r;
  logic [30:0]             xx2_r;
  logic [29:0]             aa2_r;
  logic signed [32:0]      lyz2_r;
  logic [32:0]             u2_r;
  logic [30:0]             d2_r;
  logic                    badlen2_r;

  logic signed [POS_W-1:0] x3_r, y3_r, z3_r;
  logic [29:0]             aa3_r;
  logic signed [32:0]      lyz3_r;
  logic signed [NW-1:0]    n3_r;
  logic [30:0]             d3_r;
  logic                    bad3_r;
  logic signed [33:0]      lxz_nxt;
  logic signed [NW-1:0]    n_nxt;

  assign lxz_nxt = {lyz2_r[32], lyz2_r} - $signed({3'b0, xx2_r});
  assign n_nxt   = {{(NW-33){lyz2_r[32]}}, lyz2_r} - $signed({{(NW-33){1'b0}}, u2_r});

  logic signed [POS_W-1:0] x4_r, y4_r, z4_r;
  logic signed [32:0]      lyz4_r;
  logic signed [NW-1:0]    n4_r, n2a4_r;
  logic [30:0]             d4_r, nabs4_r;
  logic                    bad4_r;
  logic signed [NW-1:0]    d_ext, nabs_nxt;

  assign d_ext    = $signed({{(NW-31){1'b0}}, d3_r});
  assign nabs_nxt = n3_r[NW-1] ? -n3_r : n3_r;

  logic signed [POS_W-1:0] x5_r, y5_r, z5_r;
  logic signed [32:0]      lyz5_r;
  logic signed [NW-1:0]    n5_r, n2a5_r;
  logic [SQ_W-1:0]         dd5_r, nn5_r;
  logic                    bad5_r;

  side_t           side6_r;
  logic [SQ_W-1:0] rad6_r, lyzsh6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r      <= in_foot_x;
      y1_r      <= in_foot_y;
      z1_r      <= in_foot_z;
      xx1_r     <= xx_nxt[30:0];
      yy1_r     <= yy_nxt[30:0];
      zz1_r     <= zz_nxt[30:0];
      ss1_r     <= shoulder_offset_r * shoulder_offset_r;
      aa1_r     <= upper_link_r * upper_link_r;
      ff1_r     <= lower_link_r * lower_link_r;
      af1_r     <= upper_link_r * lower_link_r;
      badlen1_r <= (upper_link_r == '0) || (lower_link_r == '0);

      x2_r      <= x1_r;
      y2_r      <= y1_r;
      z2_r      <= z1_r;
      xx2_r     <= xx1_r;
      aa2_r     <= aa1_r;
      lyz2_r    <= $signed({2'b0, yy1_r}) + $signed({2'b0, zz1_r}) - $signed({3'b0, ss1_r});
      u2_r      <= {2'b0, xx1_r} + {3'b0, aa1_r} + {3'b0, ff1_r};
      d2_r      <= {af1_r, 1'b0};
      badlen2_r <= badlen1_r;

      x3_r      <= x2_r;
      y3_r      <= y2_r;
      z3_r      <= z2_r;
      aa3_r     <= aa2_r;
      lyz3_r    <= lyz2_r;
      n3_r      <= n_nxt;
      d3_r      <= d2_r;
      bad3_r    <= badlen2_r || (lyz2_r <= 0) || (lxz_nxt <= 0);

      x4_r      <= x3_r;
      y4_r      <= y3_r;
      z4_r      <= z3_r;
      lyz4_r    <= lyz3_r;
      n4_r      <= n3_r;
      n2a4_r    <= n3_r + $signed({{(NW-31){1'b0}}, aa3_r, 1'b0});
      d4_r      <= d3_r;
      nabs4_r   <= nabs_nxt[30:0];
      bad4_r    <= bad3_r || (n3_r > d_ext) || (n3_r < -d_ext);

      x5_r      <= x4_r;
      y5_r      <= y4_r;
      z5_r      <= z4_r;
      lyz5_r    <= lyz4_r;
      n5_r      <= n4_r;
      n2a5_r    <= n2a4_r;
      dd5_r     <= d4_r * d4_r;
      nn5_r     <= nabs4_r * nabs4_r;
      bad5_r    <= bad4_r;

      side6_r   <= '{bad: bad5_r, x: x5_r, y: y5_r, z: z5_r, n: n5_r, n2a: n2a5_r};
      rad6_r    <= dd5_r - nn5_r;
      lyzsh6_r  <= {14'b0, lyz5_r[31:0], 16'b0};
    end
  end

  // roots
  logic [SQ_W/2-1:0] sn, rt;
  side_t             side_r [SQ_STAGES];

  lik_sqrt u_sqrt_sn (.clk(clk), .en(en), .rad(rad6_r),   .root(sn));
  lik_sqrt u_sqrt_r  (.clk(clk), .en(en), .rad(lyzsh6_r), .root(rt));

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side6_r;
      for (int k = 1; k < SQ_STAGES; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // angles
  side_t                     sd;
  logic signed [AT_IN_W-1:0] sn_a, n_a, n2a_a, y_a, z_a, s_a, x_a, r_a;
  logic signed [ACC_W-1:0]   fa_ang, bend_ang, g1_ang, g2_ang, a1_ang;
  logic                      bad_r [AtanLat];

  assign sd    = side_r[SQ_STAGES-1];
  assign sn_a  = $signed({{(AT_IN_W-SQ_W/2){1'b0}}, sn});
  assign r_a   = $signed({{(AT_IN_W-SQ_W/2){1'b0}}, rt});
  assign n_a   = {{(AT_IN_W-NW){sd.n[NW-1]}}, sd.n};
  assign n2a_a = {{(AT_IN_W-NW){sd.n2a[NW-1]}}, sd.n2a};
  assign y_a   = {{(AT_IN_W-POS_W){sd.y[POS_W-1]}}, sd.y};
  assign z_a   = {{(AT_IN_W-POS_W){sd.z[POS_W-1]}}, sd.z};
  assign s_a   = $signed({{(AT_IN_W-LEN_W-8){1'b0}}, shoulder_offset_r, 8'b0});
  assign x_a   = {{(AT_IN_W-POS_W-8){sd.x[POS_W-1]}}, sd.x, 8'b0};

  lik_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_at_fa
    (.clk(clk), .en(en), .y_in(sn_a), .x_in(n_a),   .ang(fa_ang));
  lik_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_at_bend
    (.clk(clk), .en(en), .y_in(sn_a), .x_in(n2a_a), .ang(bend_ang));
  lik_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_at_g1
    (.clk(clk), .en(en), .y_in(y_a),  .x_in(z_a),   .ang(g1_ang));
  lik_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_at_g2
    (.clk(clk), .en(en), .y_in(s_a),  .x_in(r_a),   .ang(g2_ang));
  lik_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_at_a1
    (.clk(clk), .en(en), .y_in(x_a),  .x_in(r_a),   .ang(a1_ang));

  always_ff @(posedge clk) begin
    if (en) begin
      bad_r[0] <= sd.bad;
      for (int k = 1; k < AtanLat; k++) begin
        bad_r[k] <= bad_r[k-1];
      end
    end
  end

  // final sums and rounding
  logic signed [ACC_W-1:0] shq_r, armq_r, faq_r;
  logic                    badf_r;
  logic signed [ACC_W-1:0] sh_v, arm_v, fa_v;

  assign sh_v  = (shq_r + Half) >>> ShOut;
  assign arm_v = (armq_r + Half) >>> ShOut;
  assign fa_v  = (faq_r + Half) >>> ShOut;

  function automatic logic signed [15:0] sat_s16(input logic signed [ACC_W-1:0] v);
    if (v < -32768) return 16'sh8000;
    if (v > 32767)  return 16'sh7FFF;
    return v[15:0];
  endfunction

  function automatic logic [13:0] sat_u14(input logic signed [ACC_W-1:0] v);
    if (v < 0)     return '0;
    if (v > 16383) return 14'h3FFF;
    return v[13:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      shq_r  <= PI_Q30 - g1_ang - g2_ang;
      armq_r <= bend_ang - a1_ang;
      faq_r  <= fa_ang;
      badf_r <= bad_r[AtanLat-1];

      out_shoulder_angle <= badf_r ? '0 : sat_s16(sh_v);
      out_arm_angle      <= badf_r ? '0 : sat_s16(arm_v);
      out_forearm_angle  <= badf_r ? '0 : sat_u14(fa_v);
      out_unreachable    <= badf_r;
    end
  end

  assign out_valid = vld_r[Lat-1];

endmodule
